>>> hw/rtl/lpta_pkg.sv
// ----------------------------------------------------------------------------
// lpta_pkg
// Shared types, constants and the arctangent table for the point timestamp
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package lpta_pkg;

   localparam int RINGS_DEF      = 128;
   localparam int ANGLE_BITS_DEF = 16;

   localparam int CORDIC_STEPS = 28;
   localparam int STEP_W       = 5;
   localparam int CORDIC_W     = 36;

   localparam int TIME_W   = 48;
   localparam int QUO_W    = 50;
   localparam int DIV_K    = 361;
   localparam int TIME_MUL = 36000;
   localparam int PERIOD_ROUND = 180;
   localparam logic [63:0] MIN_DIST_SQ = 64'd16777216;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] REG_POINT_FILTER = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TIME_SCALE   = 2'd1;
   localparam logic [7:0]  POINT_FILTER_RST = 8'd1;
   localparam logic [31:0] TIME_SCALE_RST   = 32'd16777216;

   typedef struct packed {
      logic               frame_start;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [6:0]         ring;
      logic [7:0]         intensity;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic [6:0]         out_ring;
      logic [7:0]         out_intensity;
      logic [47:0]        point_time;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AZ,
      ST_MUL,
      ST_Q,
      ST_DIV,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic rd_en;
      logic clear;
      logic wr_en;
      logic set_time;
   } store_cmd_type;

   typedef struct packed {
      logic known;
      logic time_valid;
   } store_flags_type;

   // atan(2^-i) as a fraction of a turn, 32 bits
   function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] i);
      logic [31:0] v;
      case (i)
         5'd0:    v = 32'd536870912;
         5'd1:    v = 32'd316933406;
         5'd2:    v = 32'd167458907;
         5'd3:    v = 32'd85004756;
         5'd4:    v = 32'd42667331;
         5'd5:    v = 32'd21354465;
         5'd6:    v = 32'd10679838;
         5'd7:    v = 32'd5340245;
         5'd8:    v = 32'd2670163;
         5'd9:    v = 32'd1335087;
         5'd10:   v = 32'd667544;
         5'd11:   v = 32'd333772;
         5'd12:   v = 32'd166886;
         5'd13:   v = 32'd83443;
         5'd14:   v = 32'd41722;
         5'd15:   v = 32'd20861;
         5'd16:   v = 32'd10430;
         5'd17:   v = 32'd5215;
         5'd18:   v = 32'd2608;
         5'd19:   v = 32'd1304;
         5'd20:   v = 32'd652;
         5'd21:   v = 32'd326;
         5'd22:   v = 32'd163;
         5'd23:   v = 32'd81;
         5'd24:   v = 32'd41;
         5'd25:   v = 32'd20;
         5'd26:   v = 32'd10;
         5'd27:   v = 32'd5;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/lpta_cordic.sv
// ----------------------------------------------------------------------------
// lpta_cordic
// Iterative vectoring CORDIC: azimuth of (x, y) as a fraction of a turn,
// one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpta_cordic #(
   parameter int ANGLE_BITS = lpta_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire logic signed [31:0]    x_start,
   input  wire logic signed [31:0]    y_start,
   output logic                       busy,
   output logic                       done,
   output logic [ANGLE_BITS-1:0]      azimuth
);

   localparam int CW = lpta_pkg::CORDIC_W;

   logic signed [CW-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [CW-1:0] dx, dy, xs, ys;
   logic [31:0] z_ff, z_in, z_round;
   logic [lpta_pkg::STEP_W-1:0] step_ff, step_in;
   logic busy_ff, busy_in, done_ff, done_in, zero_ff, zero_in;

   assign xs = CW'(x_start);
   assign ys = CW'(y_start);
   assign dx = y_ff >>> step_ff;
   assign dy = x_ff >>> step_ff;

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      zero_in = zero_ff;
      if (start) begin
         zero_in = (x_start == 32'sd0) && (y_start == 32'sd0);
         busy_in = 1'b1;
         step_in = '0;
         // left half plane: rotate by a half turn first
         if (x_start[31]) begin
            x_in = -xs;
            y_in = -ys;
            z_in = 32'h8000_0000;
         end else begin
            x_in = xs;
            y_in = ys;
            z_in = 32'd0;
         end
      end else if (busy_ff) begin
         if (y_ff[CW-1]) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - lpta_pkg::cordic_atan(step_ff);
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + lpta_pkg::cordic_atan(step_ff);
         end
         if (step_ff == lpta_pkg::STEP_W'(lpta_pkg::CORDIC_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      zero_ff <= zero_in;
   end

   // round half up to the output angle width
   assign z_round = z_ff + (32'd1 << (31 - ANGLE_BITS));
   assign azimuth = zero_ff ? '0 : z_round[31 -: ANGLE_BITS];
   assign busy    = busy_ff;
   assign done    = done_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lpta_div361.sv
// ----------------------------------------------------------------------------
// lpta_div361
// Radix-4 restoring divider by the constant 361, two quotient bits a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lpta_div361 #(
   parameter int WIDTH = lpta_pkg::QUO_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   output logic                  busy,
   output logic                  done,
   output logic [WIDTH-1:0]      quotient
);

   localparam int DIGITS = WIDTH / 2;
   localparam int CNT_W  = $clog2(DIGITS + 1);
   localparam logic [10:0] K1 = 11'(lpta_pkg::DIV_K);
   localparam logic [10:0] K2 = 11'(2 * lpta_pkg::DIV_K);
   localparam logic [10:0] K3 = 11'(3 * lpta_pkg::DIV_K);

   logic [WIDTH-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [8:0]  rem_ff, rem_in;
   logic [10:0] r4, r4_sub;
   logic [1:0]  digit;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;

   assign r4 = {rem_ff, num_ff[WIDTH-1 -: 2]};

   always_comb begin
      if (r4 >= K3) begin
         digit  = 2'd3;
         r4_sub = r4 - K3;
      end else if (r4 >= K2) begin
         digit  = 2'd2;
         r4_sub = r4 - K2;
      end else if (r4 >= K1) begin
         digit  = 2'd1;
         r4_sub = r4 - K1;
      end else begin
         digit  = 2'd0;
         r4_sub = r4;
      end
   end

   always_comb begin
      num_in  = num_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = num_ff << 2;
         quo_in = {quo_ff[WIDTH-3:0], digit};
         rem_in = r4_sub[8:0];
         if (cnt_ff == CNT_W'(DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

>>> hw/rtl/lpta_ring_store.sv
// ----------------------------------------------------------------------------
// lpta_ring_store
// Per-ring state: start azimuth and last emitted time in one memory, with
// known / time-valid flags in flip-flops that a frame start clears at once.
// ----------------------------------------------------------------------------
`default_nettype none

module lpta_ring_store #(
   parameter int RINGS      = lpta_pkg::RINGS_DEF,
   parameter int ANGLE_BITS = lpta_pkg::ANGLE_BITS_DEF,
   parameter int IDX_W      = 7
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire lpta_pkg::store_cmd_type        cmd,
   input  wire logic [IDX_W-1:0]               idx,
   input  wire logic [ANGLE_BITS-1:0]          wr_az,
   input  wire logic [lpta_pkg::TIME_W-1:0]    wr_time,
   output lpta_pkg::store_flags_type           rd_flags,
   output logic [ANGLE_BITS-1:0]               rd_az,
   output logic [lpta_pkg::TIME_W-1:0]         rd_time
);

   localparam int WORD_W = ANGLE_BITS + lpta_pkg::TIME_W;

   logic [WORD_W-1:0] mem [RINGS];
   logic [WORD_W-1:0] rd_word_ff;
   logic [RINGS-1:0] known_ff, known_in, tvalid_ff, tvalid_in;
   lpta_pkg::store_flags_type flags_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx] <= {wr_az, wr_time};
      end
      if (cmd.rd_en) begin
         rd_word_ff <= mem[idx];
      end
   end

   always_comb begin
      known_in  = known_ff;
      tvalid_in = tvalid_ff;
      if (cmd.clear) begin
         known_in  = '0;
         tvalid_in = '0;
      end
      if (cmd.wr_en) begin
         known_in[idx] = 1'b1;
      end
      if (cmd.set_time) begin
         tvalid_in[idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         known_ff  <= '0;
         tvalid_ff <= '0;
      end else begin
         known_ff  <= known_in;
         tvalid_ff <= tvalid_in;
      end
      // flags read as cleared when the same beat starts a new frame
      if (cmd.rd_en) begin
         flags_ff.known      <= !cmd.clear && known_ff[idx];
         flags_ff.time_valid <= !cmd.clear && tvalid_ff[idx];
      end
   end

   assign rd_flags = flags_ff;
   assign rd_az    = rd_word_ff[WORD_W-1 -: ANGLE_BITS];
   assign rd_time  = rd_word_ff[lpta_pkg::TIME_W-1:0];

endmodule

`default_nettype wire

>>> hw/rtl/lidar_point_time_from_azimuth_core.sv
// ----------------------------------------------------------------------------
// lidar_point_time_from_azimuth_core
// Timestamps spinning-scanner points from their azimuth within the ring.
// ----------------------------------------------------------------------------
// req channel: one point per beat (frame_start, x/y/z in 1/1024 m, ring,
// intensity). rsp channel: zero or one beat per point, coordinates passed
// through plus point_time with 24 fractional bits.
// csr port: register 0 point_filter, register 1 time_scale; write only
// while the block is idle.
// One point is in flight at a time: the 28-step CORDIC (one micro-rotation
// a cycle) is followed by the 25-step radix-4 divide by 361. The turn
// period divide runs beside the CORDIC. The result is registered in the
// cycle after the final write-back.
// req_stall is high while a point is in flight. A result waiting on a
// stalled rsp does not block the next point; only the following result
// waits for the output register to free.
// Synchronous reset clears control, the per-ring flags, the decimation
// count and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module lidar_point_time_from_azimuth_core #(
   parameter int RINGS      = lpta_pkg::RINGS_DEF,
   parameter int ANGLE_BITS = lpta_pkg::ANGLE_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire lpta_pkg::req_type                 req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output lpta_pkg::rsp_type                      rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [lpta_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [lpta_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W = (RINGS > 1) ? $clog2(RINGS) : 1;
   localparam int QW    = lpta_pkg::QUO_W;
   localparam int TW    = lpta_pkg::TIME_W;
   localparam int MW    = ANGLE_BITS + 24;

   lpta_pkg::state_type state_ff, state_in;
   lpta_pkg::req_type   pt_ff;
   lpta_pkg::rsp_type   rsp_data_ff;
   lpta_pkg::store_cmd_type   st_cmd;
   lpta_pkg::store_flags_type st_flags;

   logic [7:0]  pf_ff;
   logic [31:0] ts_ff;
   logic [7:0]  dcnt_ff, dcnt_in, dcnt_eff;
   logic [8:0]  dcnt_next;
   logic accept, keep_ff, ring_ok, ring_ok_ff, go, emit;
   logic [8:0] ring_ext;
   logic [IDX_W-1:0] idx_ff;

   logic cordic_busy, cordic_done;
   logic [ANGLE_BITS-1:0] az, az_ff, start_az, delta;

   logic [47:0] m_calc, m_ff;
   logic [MW-1:0] a_ff, b_ff;
   logic [QW-1:0] q, div_dividend, div_quo;
   logic div_start, div_busy, div_done;
   logic [TW-1:0] period_ff, t_sat, last_t, t_ff, t_in;
   logic [TW:0]   t_sum;

   logic [ANGLE_BITS-1:0] rd_az;
   logic [TW-1:0] rd_time;

   logic [2:0]  dstep_ff;
   logic [31:0] mag_sel;
   logic [63:0] prod_ff, acc_ff;
   logic rsp_valid_ff, rsp_load;

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? (~v + 32'd1) : v;
   endfunction

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pf_ff <= lpta_pkg::POINT_FILTER_RST;
         ts_ff <= lpta_pkg::TIME_SCALE_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            lpta_pkg::REG_POINT_FILTER: pf_ff <= csr_wdata[7:0];
            lpta_pkg::REG_TIME_SCALE:   ts_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign accept   = req_valid && !req_stall;
   assign ring_ext = 9'(req_data.ring);
   assign ring_ok  = ring_ext < 9'(RINGS);

   // decimation, restarted by frame start
   assign dcnt_eff  = req_data.frame_start ? 8'd0 : dcnt_ff;
   assign dcnt_next = 9'(dcnt_eff) + 9'd1;
   assign dcnt_in   = (dcnt_next >= 9'(pf_ff)) ? 8'd0 : dcnt_next[7:0];

   assign m_calc = 48'(ts_ff) * 48'(lpta_pkg::TIME_MUL);

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (accept) begin
         dcnt_ff <= dcnt_in;
      end
      if (accept) begin
         pt_ff      <= req_data;
         keep_ff    <= (dcnt_eff == 8'd0);
         ring_ok_ff <= ring_ok;
         idx_ff     <= ring_ext[IDX_W-1:0];
         m_ff       <= m_calc;
      end
   end

   // squared distance over three multiplies while the CORDIC runs
   always_comb begin
      case (dstep_ff)
         3'd0:    mag_sel = mag32(pt_ff.pos_x);
         3'd1:    mag_sel = mag32(pt_ff.pos_y);
         default: mag_sel = mag32(pt_ff.pos_z);
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         dstep_ff <= '0;
         acc_ff   <= '0;
      end else if (state_ff == lpta_pkg::ST_AZ && dstep_ff != 3'd4) begin
         dstep_ff <= dstep_ff + 3'd1;
         if (dstep_ff != 3'd0) begin
            acc_ff <= acc_ff + prod_ff;
         end
      end
      prod_ff <= mag_sel * mag_sel;
   end

   lpta_cordic #(.ANGLE_BITS(ANGLE_BITS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .x_start (req_data.pos_x),
      .y_start (req_data.pos_y),
      .busy    (cordic_busy),
      .done    (cordic_done),
      .azimuth (az)
   );

   // turn period first, then the point time
   assign div_start    = accept || (state_ff == lpta_pkg::ST_Q);
   assign div_dividend = accept ? (QW'(m_calc) + QW'(lpta_pkg::PERIOD_ROUND)) : q;

   lpta_div361 #(.WIDTH(QW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .busy     (div_busy),
      .done     (div_done),
      .quotient (div_quo)
   );

   lpta_ring_store #(
      .RINGS      (RINGS),
      .ANGLE_BITS (ANGLE_BITS),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .cmd      (st_cmd),
      .idx      (accept ? ring_ext[IDX_W-1:0] : idx_ff),
      .wr_az    (start_az),
      .wr_time  (emit ? t_ff : rd_time),
      .rd_flags (st_flags),
      .rd_az    (rd_az),
      .rd_time  (rd_time)
   );

   assign start_az = st_flags.known ? rd_az : az_ff;
   assign delta    = start_az - az_ff;
   assign q = (QW'(a_ff) << (24 - ANGLE_BITS))
            + ((QW'(b_ff) + (QW'(lpta_pkg::DIV_K) << (ANGLE_BITS - 1))) >> ANGLE_BITS);

   assign last_t = st_flags.time_valid ? rd_time : '0;
   assign t_sat  = (|div_quo[QW-1:TW]) ? lpta_pkg::TIME_MAX : div_quo[TW-1:0];
   assign t_sum  = (TW+1)'(t_sat) + (TW+1)'(period_ff);

   // a time that goes backwards wraps into the next turn
   always_comb begin
      if (t_sat < last_t) begin
         t_in = t_sum[TW] ? lpta_pkg::TIME_MAX : t_sum[TW-1:0];
      end else begin
         t_in = t_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (cordic_done) begin
         az_ff <= az;
      end
      if (div_done && state_ff == lpta_pkg::ST_AZ) begin
         period_ff <= div_quo[TW-1:0];
      end
      if (state_ff == lpta_pkg::ST_MUL) begin
         a_ff <= delta * m_ff[47:24];
         b_ff <= delta * m_ff[23:0];
      end
      if (div_done && state_ff == lpta_pkg::ST_DIV) begin
         t_ff <= t_in;
      end
   end

   assign emit = keep_ff && ring_ok_ff && (acc_ff >= lpta_pkg::MIN_DIST_SQ);
   assign go   = !(emit && rsp_valid_ff && rsp_stall);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpta_pkg::ST_IDLE:  if (accept) state_in = lpta_pkg::ST_AZ;
         lpta_pkg::ST_AZ:    if (cordic_done) state_in = lpta_pkg::ST_MUL;
         lpta_pkg::ST_MUL:   state_in = lpta_pkg::ST_Q;
         lpta_pkg::ST_Q:     state_in = lpta_pkg::ST_DIV;
         lpta_pkg::ST_DIV:   if (div_done) state_in = lpta_pkg::ST_WRITE;
         lpta_pkg::ST_WRITE: if (go) state_in = lpta_pkg::ST_IDLE;
         default:            state_in = lpta_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall       = (state_ff != lpta_pkg::ST_IDLE);
      st_cmd.rd_en    = accept && ring_ok;
      st_cmd.clear    = accept && req_data.frame_start;
      st_cmd.wr_en    = (state_ff == lpta_pkg::ST_WRITE) && ring_ok_ff && go;
      st_cmd.set_time = (state_ff == lpta_pkg::ST_WRITE) && emit && go;
      rsp_load        = (state_ff == lpta_pkg::ST_WRITE) && emit && go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lpta_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (rsp_load) begin
         rsp_data_ff.out_x         <= pt_ff.pos_x;
         rsp_data_ff.out_y         <= pt_ff.pos_y;
         rsp_data_ff.out_z         <= pt_ff.pos_z;
         rsp_data_ff.out_ring      <= pt_ff.ring;
         rsp_data_ff.out_intensity <= pt_ff.intensity;
         rsp_data_ff.point_time    <= t_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // the turn period divide must be finished before the azimuth is ready
   a_period_before_az: assert property (@(posedge clock) disable iff (reset)
      cordic_done |-> !div_busy)
      else $error("period divide still running at cordic done");

   a_accept_starts_cordic: assert property (@(posedge clock) disable iff (reset)
      accept |=> cordic_busy)
      else $error("cordic not started by accepted beat");

   a_write_in_range: assert property (@(posedge clock) disable iff (reset)
      st_cmd.wr_en |-> (state_ff == lpta_pkg::ST_WRITE) && ring_ok_ff)
      else $error("ring store written outside write-back");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("output register overwritten while stalled");

   a_result_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == lpta_pkg::ST_WRITE && emit))
      else $error("result without an emitted point");

endmodule

`default_nettype wire
